/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the fan triangulator.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

/* rtl/core/pfn_pkg.sv */
// Shared types and constants of the fan triangulator.
// No dependencies.
package pfn_pkg;
  localparam int POS_W  = 32;
  localparam int NRM_W  = 16;
  localparam int SUM_W  = NRM_W + 2;
  localparam int EDGE_W = POS_W + 1;
  localparam int VEC_W  = 2 * POS_W + 2;
  localparam int QDEPTH = 2;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  localparam logic [1:0] CORNER_APEX = 2'd0;
  localparam logic [1:0] CORNER_PREV = 2'd1;
  localparam logic [1:0] CORNER_CUR  = 2'd2;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [NRM_W-1:0]  nrm_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [EDGE_W-1:0] edge_t;

  typedef struct packed {
    logic            err;
    pos_t [2:0]      apex;
    pos_t [2:0]      prev;
    pos_t [2:0]      cur;
    sum_t [2:0]      sum;
    edge_t [2:0]     e1;
    edge_t [2:0]     e2;
  } job_t;
endpackage

/* rtl/core/pfn_front.sv */
// Front end: takes vertices, tracks apex and previous vertex, builds jobs.
// Depends on pfn_pkg.
module pfn_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfn_pkg::pos_t       in_pos_x,
  input  pfn_pkg::pos_t       in_pos_y,
  input  pfn_pkg::pos_t       in_pos_z,
  input  logic                in_vertex_present,
  input  pfn_pkg::nrm_t       in_norm_x,
  input  pfn_pkg::nrm_t       in_norm_y,
  input  pfn_pkg::nrm_t       in_norm_z,
  input  logic                in_normal_present,
  input  logic                in_polygon_end,
  input  logic                q_full,
  output logic                q_push,
  output pfn_pkg::job_t       q_job
);
  import pfn_pkg::*;

  pos_t [2:0] apex_pos_r, prev_pos_r, pv;
  nrm_t [2:0] apex_nrm_r, prev_nrm_r, nv;
  logic [1:0] vs_r, vs_nxt;
  logic       accept, tri_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign tri_ok   = (vs_r == 2'd2);
  assign q_push   = accept && (tri_ok || in_polygon_end);

  always_comb begin
    pv[0] = in_vertex_present ? in_pos_x : '0;
    pv[1] = in_vertex_present ? in_pos_y : '0;
    pv[2] = in_vertex_present ? in_pos_z : '0;
    nv[0] = in_normal_present ? in_norm_x : '0;
    nv[1] = in_normal_present ? in_norm_y : '0;
    nv[2] = in_normal_present ? in_norm_z : '0;
    q_job.err  = !tri_ok;
    q_job.apex = apex_pos_r;
    q_job.prev = prev_pos_r;
    q_job.cur  = pv;
    for (int i = 0; i < 3; i++) begin
      q_job.sum[i] = SUM_W'($signed(apex_nrm_r[i])) + SUM_W'($signed(prev_nrm_r[i]))
                   + SUM_W'($signed(nv[i]));
      q_job.e1[i]  = EDGE_W'($signed(prev_pos_r[i])) - EDGE_W'($signed(apex_pos_r[i]));
      q_job.e2[i]  = EDGE_W'($signed(pv[i])) - EDGE_W'($signed(apex_pos_r[i]));
    end
    if (in_polygon_end) begin
      vs_nxt = 2'd0;
    end else if (tri_ok) begin
      vs_nxt = 2'd2;
    end else begin
      vs_nxt = vs_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 2'd0;
    end else if (accept) begin
      vs_r <= vs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (vs_r == 2'd0) begin
        apex_pos_r <= pv;
        apex_nrm_r <= nv;
      end
      prev_pos_r <= pv;
      prev_nrm_r <= nv;
    end
  end
endmodule

/* rtl/core/pfn_queue.sv */
// Short job queue between the front end and the back end.
// Depends on pfn_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pfn_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pfn_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output pfn_pkg::job_t head_job
);
  import pfn_pkg::*;

  job_t            mem_r [QDEPTH];
  logic [QA_W-1:0] wp_r, rp_r;
  logic [QC_W-1:0] cnt_r;

  assign full       = (cnt_r == QC_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QA_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == QA_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  `ASSERT_IMPL(a_no_overflow, push, !full)
  `ASSERT_IMPL(a_no_underflow, pop, head_valid)
  `ASSERT_ALWAYS(a_cnt_range, cnt_r <= QC_W'(QDEPTH))
endmodule

/* rtl/core/pfn_back.sv */
// Back end: cross product (only when the normal sum is zero), normalization and corner output sequencing.
// Depends on pfn_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pfn_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  pfn_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output pfn_pkg::pos_t out_corner_x,
  output pfn_pkg::pos_t out_corner_y,
  output pfn_pkg::pos_t out_corner_z,
  output pfn_pkg::nrm_t out_unit_nx,
  output pfn_pkg::nrm_t out_unit_ny,
  output pfn_pkg::nrm_t out_unit_nz,
  output logic [1:0]    out_corner_index,
  output logic          out_last_of_run,
  output logic          out_short_polygon_error
);
  import pfn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ABS, S_SHIFT, S_SQ, S_DLOAD, S_DIV, S_SQRT, S_EMIT
  } state_t;

  state_t                  state_r;
  job_t                    job_r;
  logic [2:0]              cnt_r;
  logic [2*POS_W-1:0]      prod_r;
  logic                    pneg_r;
  logic signed [VEC_W-1:0] acc_r [3];
  logic [VEC_W-1:0]        mag_r [3];
  logic [2:0]              neg_r;
  logic [31:0]             ssum_r;
  logic [1:0]              comp_r;
  logic [31:0]             rem_r;
  logic [30:0]             dlo_r;
  logic [30:0]             quo_r;
  logic [4:0]              stp_r;
  logic [31:0]             sx_r, root_r;
  nrm_t                    un_r [3];
  pos_t                    ox_r, oy_r, oz_r;
  logic [1:0]              corner_r;
  logic                    out_valid_r;

  // multiplier operands
  edge_t              ea, eb;
  logic [POS_W-1:0]   ma, mb;
  logic [2*POS_W-1:0] prod;
  logic [1:0]         pidx;
  logic [VEC_W-1:0]   pext;
  // normalization
  logic               big, mid;
  logic [29:0]        sq;
  logic [31:0]        stot;
  logic [32:0]        trial;
  logic               ge;
  logic [30:0]        quo_n;
  logic [31:0]        bitv, rtrial, root_n;
  logic [16:0]        rnd;
  logic [15:0]        uval;
  logic               is_last;
  logic [1:0]         ld_c;
  pos_t [2:0]         ld_pos;

  always_comb begin
    case (cnt_r)
      3'd0: begin ea = job_r.e1[1]; eb = job_r.e2[2]; end
      3'd1: begin ea = job_r.e1[2]; eb = job_r.e2[1]; end
      3'd2: begin ea = job_r.e1[2]; eb = job_r.e2[0]; end
      3'd3: begin ea = job_r.e1[0]; eb = job_r.e2[2]; end
      3'd4: begin ea = job_r.e1[0]; eb = job_r.e2[1]; end
      3'd5: begin ea = job_r.e1[1]; eb = job_r.e2[0]; end
      default: begin ea = '0; eb = '0; end
    endcase
    ma   = ea[EDGE_W-1] ? POS_W'(-ea) : POS_W'(ea);
    mb   = eb[EDGE_W-1] ? POS_W'(-eb) : POS_W'(eb);
    prod = ma * mb;
    pidx = 2'((cnt_r - 3'd1) >> 1);
    pext = {2'b00, prod_r};

    big = (|mag_r[0][VEC_W-1:31]) || (|mag_r[1][VEC_W-1:31]) || (|mag_r[2][VEC_W-1:31]);
    mid = (|mag_r[0][VEC_W-1:15]) || (|mag_r[1][VEC_W-1:15]) || (|mag_r[2][VEC_W-1:15]);
    sq   = mag_r[comp_r][14:0] * mag_r[comp_r][14:0];
    stot = ssum_r + {2'b00, sq};

    trial = {rem_r, dlo_r[30]};
    ge    = (trial >= {1'b0, ssum_r});
    quo_n = {quo_r[29:0], ge};

    bitv   = 32'd1 << (5'd30 - {stp_r[3:0], 1'b0});
    rtrial = root_r + bitv;
    root_n = (sx_r >= rtrial) ? ((root_r >> 1) + bitv) : (root_r >> 1);
    rnd    = root_n[16:0] + 17'd1;
    uval   = rnd[16:1];

    is_last = job_r.err || (corner_r == CORNER_CUR);
    ld_c    = (state_r == S_EMIT) ? corner_r + 2'd1 : CORNER_APEX;
    case (ld_c)
      CORNER_APEX: ld_pos = job_r.apex;
      CORNER_PREV: ld_pos = job_r.prev;
      default:     ld_pos = job_r.cur;
    endcase
  end

  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            job_r <= q_job;
            cnt_r <= '0;
            if (q_job.err) begin
              ox_r        <= '0;
              oy_r        <= '0;
              oz_r        <= '0;
              for (int i = 0; i < 3; i++) un_r[i] <= '0;
              corner_r    <= CORNER_APEX;
              out_valid_r <= 1'b1;
              state_r     <= S_EMIT;
            end else if (q_job.sum != '0) begin
              for (int i = 0; i < 3; i++) acc_r[i] <= VEC_W'($signed(q_job.sum[i]));
              state_r <= S_ABS;
            end else begin
              for (int i = 0; i < 3; i++) acc_r[i] <= '0;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // multiply this product, accumulate the one before
          prod_r <= prod;
          pneg_r <= ea[EDGE_W-1] ^ eb[EDGE_W-1] ^ cnt_r[0];
          if (cnt_r != 3'd0) begin
            acc_r[pidx] <= pneg_r ? acc_r[pidx] - $signed(pext)
                                  : acc_r[pidx] + $signed(pext);
          end
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd6) begin
            state_r <= S_ABS;
          end
        end
        S_ABS: begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= acc_r[i][VEC_W-1];
            mag_r[i] <= acc_r[i][VEC_W-1] ? VEC_W'(-acc_r[i]) : VEC_W'(acc_r[i]);
          end
          state_r <= S_SHIFT;
        end
        S_SHIFT: begin
          if (big) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 16;
          end else if (mid) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else begin
            ssum_r  <= '0;
            comp_r  <= 2'd0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          ssum_r <= stot;
          if (comp_r == 2'd2) begin
            comp_r <= 2'd0;
            if (stot == '0) begin
              for (int i = 0; i < 3; i++) un_r[i] <= '0;
              ox_r        <= ld_pos[0];
              oy_r        <= ld_pos[1];
              oz_r        <= ld_pos[2];
              corner_r    <= CORNER_APEX;
              out_valid_r <= 1'b1;
              state_r     <= S_EMIT;
            end else begin
              state_r <= S_DLOAD;
            end
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end
        S_DLOAD: begin
          // quotient of s*s*2^30 / S stays below 2^31, so start at bit 30
          rem_r   <= {3'b000, sq[29:1]};
          dlo_r   <= {sq[0], 30'd0};
          quo_r   <= '0;
          stp_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= ge ? 32'(trial - {1'b0, ssum_r}) : trial[31:0];
          dlo_r <= {dlo_r[29:0], 1'b0};
          quo_r <= quo_n;
          stp_r <= stp_r + 5'd1;
          if (stp_r == 5'd30) begin
            sx_r    <= {1'b0, quo_n};
            root_r  <= '0;
            stp_r   <= '0;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sx_r >= rtrial) begin
            sx_r <= sx_r - rtrial;
          end
          root_r <= root_n;
          stp_r  <= stp_r + 5'd1;
          if (stp_r == 5'd15) begin
            un_r[comp_r] <= neg_r[comp_r] ? NRM_W'(-uval) : NRM_W'(uval);
            if (comp_r == 2'd2) begin
              ox_r        <= ld_pos[0];
              oy_r        <= ld_pos[1];
              oz_r        <= ld_pos[2];
              corner_r    <= CORNER_APEX;
              out_valid_r <= 1'b1;
              state_r     <= S_EMIT;
            end else begin
              comp_r  <= comp_r + 2'd1;
              state_r <= S_DLOAD;
            end
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (is_last) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              corner_r <= ld_c;
              ox_r     <= ld_pos[0];
              oy_r     <= ld_pos[1];
              oz_r     <= ld_pos[2];
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid               = out_valid_r;
  assign out_corner_x            = ox_r;
  assign out_corner_y            = oy_r;
  assign out_corner_z            = oz_r;
  assign out_unit_nx             = un_r[0];
  assign out_unit_ny             = un_r[1];
  assign out_unit_nz             = un_r[2];
  assign out_corner_index        = corner_r;
  assign out_last_of_run         = is_last;
  assign out_short_polygon_error = job_r.err;

  `ASSERT_ALWAYS(a_valid_in_emit, (state_r == S_EMIT) == out_valid_r)
  `ASSERT_IMPL(a_err_single, out_valid_r && job_r.err, corner_r == CORNER_APEX)
  `ASSERT_IMPL(a_corner_range, out_valid_r, corner_r != 2'd3)
  `ASSERT_IMPL(a_norm_range, out_valid_r, (un_r[0] <= 16384) && (un_r[0] >= -16384))
endmodule

/* rtl/core/polygon_fan_triangulator_with_normals.sv */
// Top level of the fan triangulator with face normals.
// Depends on pfn_pkg, pfn_front, pfn_queue and pfn_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------
//   in_      | in_valid / in_ready    | position, normal, present flags, end
//   out_     | out_valid / out_ready  | corner, unit normal, index, flags
//
// A vertex that opens a polygon yields no beat unless it also ends the polygon.
// A triangle: a load, a cross product when the normal sum is zero, the
// magnitude, a shift search and the squares, then per component a load,
// 31 divide and 16 square root steps, then three output beats.
// A short polygon's beat passes through the queue and is registered in the back end before it is offered.
// Reset is synchronous; the input stalls once two jobs wait behind the one in work.
module polygon_fan_triangulator_with_normals (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pfn_pkg::pos_t in_pos_x,
  input  pfn_pkg::pos_t in_pos_y,
  input  pfn_pkg::pos_t in_pos_z,
  input  logic          in_vertex_present,
  input  pfn_pkg::nrm_t in_norm_x,
  input  pfn_pkg::nrm_t in_norm_y,
  input  pfn_pkg::nrm_t in_norm_z,
  input  logic          in_normal_present,
  input  logic          in_polygon_end,
  output logic          out_valid,
  input  logic          out_ready,
  output pfn_pkg::pos_t out_corner_x,
  output pfn_pkg::pos_t out_corner_y,
  output pfn_pkg::pos_t out_corner_z,
  output pfn_pkg::nrm_t out_unit_nx,
  output pfn_pkg::nrm_t out_unit_ny,
  output pfn_pkg::nrm_t out_unit_nz,
  output logic [1:0]    out_corner_index,
  output logic          out_last_of_run,
  output logic          out_short_polygon_error
);
  import pfn_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  job_t push_job, head_job;

  pfn_front u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_pos_x, .in_pos_y, .in_pos_z, .in_vertex_present,
    .in_norm_x, .in_norm_y, .in_norm_z, .in_normal_present, .in_polygon_end,
    .q_full, .q_push, .q_job(push_job)
  );

  pfn_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_job, .full(q_full),
    .pop(q_pop), .head_valid(q_valid), .head_job
  );

  pfn_back u_back (
    .clk, .rst_n, .q_valid, .q_job(head_job), .q_pop,
    .out_valid, .out_ready, .out_corner_x, .out_corner_y, .out_corner_z,
    .out_unit_nx, .out_unit_ny, .out_unit_nz, .out_corner_index,
    .out_last_of_run, .out_short_polygon_error
  );
endmodule

/* tb/polygon_fan_triangulator_with_normals_tb.sv */
// Self-checking testbench for the fan triangulator with face normals.
// Depends on pfn_pkg and polygon_fan_triangulator_with_normals; predicts corners in a class.
`timescale 1ns / 1ps

module polygon_fan_triangulator_with_normals_tb;
  import pfn_pkg::*;

  typedef struct {
    pos_t       x, y, z;
    nrm_t       nx, ny, nz;
    logic [1:0] idx;
    logic       last;
    logic       err;
  } corner_t;

  class fan_scoreboard;
    logic signed [63:0] apex_p[3], apex_n[3], prev_p[3], prev_n[3];
    int unsigned        seen;
    corner_t            pending[$];
    int                 errors;
    int                 triangles, shorts, checked;

    function new();
      for (int i = 0; i < 3; i++) begin
        apex_p[i] = 0; apex_n[i] = 0; prev_p[i] = 0; prev_n[i] = 0;
      end
      seen = 0; errors = 0; triangles = 0; shorts = 0; checked = 0;
    endfunction

    function logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Scale to 15 significant bits, then round s*2^14/sqrt(S) half up.
    function void unit_vector(logic signed [127:0] v[3], output nrm_t un[3]);
      logic [127:0] m[3];
      logic [63:0]  s[3], tot, r;
      int           maxlen, k;
      maxlen = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = v[i] < 0 ? -v[i] : v[i];
        for (int b = 127; b >= 0; b--)
          if (m[i][b]) begin
            if (b + 1 > maxlen) maxlen = b + 1;
            break;
          end
      end
      k = maxlen > 15 ? maxlen - 15 : 0;
      tot = 0;
      for (int i = 0; i < 3; i++) begin
        s[i] = 64'(m[i] >> k);
        tot = tot + s[i] * s[i];
      end
      for (int i = 0; i < 3; i++) begin
        r = 0;
        if (tot != 0) r = (isqrt(((s[i] * s[i]) << 30) / tot) + 1) >> 1;
        un[i] = v[i] < 0 ? -nrm_t'(r) : nrm_t'(r);
      end
    endfunction

    function void note_vertex(pos_t px, pos_t py, pos_t pz, logic vp,
                              nrm_t nx, nrm_t ny, nrm_t nz, logic np, logic last);
      logic signed [63:0]  p[3], n[3], sum[3], e1[3], e2[3];
      logic signed [127:0] v[3];
      nrm_t                un[3];
      corner_t             c;
      p[0] = vp ? 64'(px) : '0; p[1] = vp ? 64'(py) : '0; p[2] = vp ? 64'(pz) : '0;
      n[0] = np ? 64'(nx) : '0; n[1] = np ? 64'(ny) : '0; n[2] = np ? 64'(nz) : '0;
      if (seen < 2) begin
        if (seen == 0) begin
          apex_p = p; apex_n = n;
        end
        prev_p = p; prev_n = n;
        seen++;
        if (last) begin
          seen = 0;
          c = '{0, 0, 0, 0, 0, 0, 2'd0, 1'b1, 1'b1};
          pending = {pending, c};
          shorts++;
        end
        return;
      end
      for (int i = 0; i < 3; i++) begin
        sum[i] = apex_n[i] + prev_n[i] + n[i];
        e1[i] = prev_p[i] - apex_p[i];
        e2[i] = p[i] - apex_p[i];
      end
      if (sum[0] != 0 || sum[1] != 0 || sum[2] != 0) begin
        for (int i = 0; i < 3; i++) v[i] = 128'(sum[i]);
      end else begin
        v[0] = 128'(e1[1]) * 128'(e2[2]) - 128'(e1[2]) * 128'(e2[1]);
        v[1] = 128'(e1[2]) * 128'(e2[0]) - 128'(e1[0]) * 128'(e2[2]);
        v[2] = 128'(e1[0]) * 128'(e2[1]) - 128'(e1[1]) * 128'(e2[0]);
      end
      unit_vector(v, un);
      for (int k = 0; k < 3; k++) begin
        c.nx = un[0]; c.ny = un[1]; c.nz = un[2];
        c.err = 1'b0;
        c.last = (k == 2);
        c.idx = k == 0 ? CORNER_APEX : (k == 1 ? CORNER_PREV : CORNER_CUR);
        if (k == 0) begin
          c.x = pos_t'(apex_p[0]); c.y = pos_t'(apex_p[1]); c.z = pos_t'(apex_p[2]);
        end else if (k == 1) begin
          c.x = pos_t'(prev_p[0]); c.y = pos_t'(prev_p[1]); c.z = pos_t'(prev_p[2]);
        end else begin
          c.x = pos_t'(p[0]); c.y = pos_t'(p[1]); c.z = pos_t'(p[2]);
        end
        pending = {pending, c};
      end
      triangles++;
      prev_p = p; prev_n = n;
      if (last) seen = 0;
    endfunction

    function void check_corner(corner_t a);
      corner_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat x=%h err=%b", $time, a.x, a.err);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.x !== e.x || a.y !== e.y || a.z !== e.z) begin
        $display("%0t: corner pos exp %h %h %h got %h %h %h", $time,
                 e.x, e.y, e.z, a.x, a.y, a.z);
        errors++;
      end
      if (a.nx !== e.nx || a.ny !== e.ny || a.nz !== e.nz) begin
        $display("%0t: normal exp %0d %0d %0d got %0d %0d %0d", $time,
                 e.nx, e.ny, e.nz, a.nx, a.ny, a.nz);
        errors++;
      end
      if (a.idx !== e.idx || a.last !== e.last || a.err !== e.err) begin
        $display("%0t: flags idx/last/err exp %0d %b %b got %0d %b %b", $time,
                 e.idx, e.last, e.err, a.idx, a.last, a.err);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_valid = 1'b0, in_vertex_present = 1'b0, in_normal_present = 1'b0;
  logic in_polygon_end = 1'b0, out_ready = 1'b0;
  pos_t in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  nrm_t in_norm_x = '0, in_norm_y = '0, in_norm_z = '0;
  logic in_ready, out_valid, out_last_of_run, out_short_polygon_error;
  pos_t out_corner_x, out_corner_y, out_corner_z;
  nrm_t out_unit_nx, out_unit_ny, out_unit_nz;
  logic [1:0] out_corner_index;

  fan_scoreboard board;
  int  idle_pct = 37;
  bit  hold_off = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  polygon_fan_triangulator_with_normals i_dut (.*);

  // Hold valid between back-to-back beats; drop it only while idling.
  task automatic send_vertex(pos_t px, pos_t py, pos_t pz, logic vp,
                             nrm_t nx, nrm_t ny, nrm_t nz, logic np, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz; in_vertex_present <= vp;
    in_norm_x <= nx; in_norm_y <= ny; in_norm_z <= nz; in_normal_present <= np;
    in_polygon_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_vertex(px, py, pz, vp, nx, ny, nz, np, last);
  endtask

  task automatic random_vertex(logic last);
    pos_t p[3];
    nrm_t n[3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(3))
        0: p[i] = $urandom;
        1: p[i] = $signed($urandom_range(65535)) - 32768;
        2: p[i] = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
        default: p[i] = $signed($urandom_range(2000)) <<< 16;
      endcase
      case ($urandom_range(3))
        0: n[i] = nrm_t'($urandom);
        1: n[i] = 0;
        2: n[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        default: n[i] = nrm_t'($signed($urandom_range(200)) - 100);
      endcase
    end
    send_vertex(p[0], p[1], p[2], $urandom_range(9) != 0,
                n[0], n[1], n[2], $urandom_range(2) != 0, last);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (board.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Receiver: random stalls, sampled at the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_corner('{out_corner_x, out_corner_y, out_corner_z, out_unit_nx,
                           out_unit_ny, out_unit_nz, out_corner_index,
                           out_last_of_run, out_short_polygon_error});
    out_ready <= !hold_off && ($urandom_range(99) >= idle_pct);
  end

  initial begin
    int nverts;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short polygons: one vertex, two vertices.
    send_vertex(32'sh7fffffff, 32'sh80000000, 0, 1, 16'sh7fff, 16'sh8000, 0, 1, 1);
    send_vertex(1, 2, 3, 1, 0, 0, 0, 0, 0);
    send_vertex(4, 5, 6, 0, 1, 1, 1, 1, 1);
    // Cross-product normal: zero vertex normals.
    send_vertex(0, 0, 0, 1, 0, 0, 0, 0, 0);
    send_vertex(32'sh10000, 0, 0, 1, 0, 0, 0, 0, 0);
    send_vertex(0, 32'sh10000, 0, 1, 0, 0, 0, 0, 0);
    // Extreme positions, extreme cross product.
    send_vertex(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1, 0, 0, 0, 0, 0);
    send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1, 0, 0, 0, 0, 1);
    // Degenerate: collinear corners, normals summing to zero.
    send_vertex(0, 0, 0, 1, 16'sh4000, 0, 0, 1, 0);
    send_vertex(1, 1, 1, 1, 16'shc000, 0, 0, 1, 0);
    send_vertex(2, 2, 2, 1, 0, 0, 0, 1, 0);
    // Normal sum path with extreme normals, vertex absent.
    send_vertex(32'sh12345678, 5, 7, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1, 0);
    send_vertex(9, 9, 9, 1, 16'sh8000, 16'sh8000, 16'sh8000, 1, 1);
    wait_drained();

    // Long hold-off: fill the block while the sender keeps going.
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      begin
        idle_pct = 0;
        for (int i = 0; i < 8; i++) random_vertex(i == 7);
        idle_pct = 37;
      end
    join
    wait_drained();

    // Random polygons, mostly 3..8 vertices; a stretch with no idling.
    nverts = 0;
    while (nverts < 160) begin
      int len;
      len = $urandom_range(9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 8);
      idle_pct = (nverts > 60 && nverts < 100) ? 0 : 37;
      for (int i = 0; i < len; i++) random_vertex(i == len - 1);
      nverts += len;
    end
    idle_pct = 37;
    wait_drained();
    repeat (300) @(posedge clk);

    $display("Covered %0d triangles and %0d short polygons, %0d beats checked.",
             board.triangles, board.shorts, board.checked);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("polygon_fan_triangulator_with_normals test passed");
    else
      $display("polygon_fan_triangulator_with_normals test failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("polygon_fan_triangulator_with_normals test failed");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/pfn_pkg.sv
rtl/core/pfn_front.sv
rtl/core/pfn_queue.sv
rtl/core/pfn_back.sv
rtl/core/polygon_fan_triangulator_with_normals.sv
tb/polygon_fan_triangulator_with_normals_tb.sv
